// ===== rtl/one_shot_timer_table_core_defines.svh =====
// ----------------------------------------------------------------------------
// One-shot timer table: assertion macros
// Concurrent assertion helpers shared by the timer table RTL. They are
// empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ONE_SHOT_TIMER_TABLE_CORE_DEFINES_SVH
`define ONE_SHOT_TIMER_TABLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define OSTT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("one_shot_timer_table_core: assertion failed");
// Expression must never be true outside reset
`define OSTT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("one_shot_timer_table_core: forbidden condition seen");
`else
`define OSTT_ASSERT(lbl, prop)
`define OSTT_NEVER(lbl, expr)
`endif

`endif

// ===== rtl/ostt_pkg.sv =====
// ----------------------------------------------------------------------------
// One-shot timer table: package
// Status and kind codes, register indexes, and the token and commit
// records that travel between the control logic and the slot cells.
// ----------------------------------------------------------------------------
package ostt_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_SCHEDULED = 3'd0,
    ST_PENDING   = 3'd1,
    ST_FULL      = 3'd2,
    ST_DISABLED  = 3'd3,
    ST_FIRED     = 3'd4,
    ST_NONE      = 3'd5
  } status_e;

  // Input item kinds
  localparam logic KIND_SCHED = 1'b0;
  localparam logic KIND_CHECK = 1'b1;

  // Configuration register indexes
  localparam logic [0:0] CFG_ENABLE = 1'b0;
  localparam logic [0:0] CFG_SLOTS  = 1'b1;

  localparam int unsigned CFG_W      = 5;
  localparam int unsigned SLOTS_RST  = 16;

  // Item token walking down the row of cells
  typedef struct packed {
    logic        valid;
    logic        en;         // bank was enabled when the item was taken
    logic        kind;
    logic [7:0]  task_id;    // already masked to the task id width
    logic [31:0] interval;
    logic [31:0] now;
    logic        pend;       // task id found in an active slot
    logic        free_seen;  // a free slot has been passed
  } tok_t;

  // Slot claim broadcast at the end of a schedule sweep
  typedef struct packed {
    logic        valid;
    logic [7:0]  task_id;
    logic [31:0] interval;
    logic [31:0] start;
  } commit_t;

endpackage

// ===== rtl/one_shot_timer_table_core.sv =====
// ----------------------------------------------------------------------------
// One-shot timer table core
// Bank of one-shot timer slots held in a row of cells. Schedule items claim
// the lowest free slot; check items fire every expired slot in index order.
// ----------------------------------------------------------------------------
// Each item is taken into an input register and then walks the row of SLOTS
// cells, one cell per clock unless the row is stalled because a fire must push
// a held result into a full output register, before its final result is
// produced. A new item is accepted the cycle after the final result of the
// previous one is loaded, even while that result still waits in the output
// register. A check item on an enabled bank returns one fired-task result per
// expired slot, the last one marked with tlast, or a single nothing-expired
// result; every other item returns exactly one result.
`include "one_shot_timer_table_core_defines.svh"

module one_shot_timer_table_core
  import ostt_pkg::*;
#(
  parameter int unsigned SLOTS        = 16,
  parameter int unsigned TASK_ID_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Configuration write port
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  // Item input stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [71:0]      s_axis_tdata,  // task_id[7:0], interval_ms[39:8], now_ms[71:40]
  input  logic             s_axis_tuser,  // kind[0]
  // Result output stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // fired_task[7:0]
  output logic [2:0]       m_axis_tuser,  // status[2:0]
  output logic             m_axis_tlast
);

  localparam int unsigned TW    = (TASK_ID_BITS < 8) ? TASK_ID_BITS : 8;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned N_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // Configuration registers
  logic             enable_q;
  logic [CFG_W-1:0] slots_q;
  logic [N_W-1:0]   slots_ext;
  logic [N_W-1:0]   n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      slots_q  <= CFG_W'(SLOTS_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENABLE: enable_q <= cfg_wdata_i[0];
        CFG_SLOTS:  slots_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign slots_ext = N_W'(slots_q);
  assign n_eff     = (slots_ext > N_W'(SLOTS)) ? N_W'(SLOTS) : slots_ext;

  // Control and output state
  logic        busy_q;
  tok_t        item_q;
  tok_t        fin_q;
  logic        hold_valid_q;
  logic [7:0]  hold_task_q;
  logic        out_valid_q;
  status_e     out_status_q;
  logic [7:0]  out_task_q;
  logic        out_last_q;

  tok_t        tok_chain [SLOTS+1];
  logic [SLOTS-1:0] fire;
  logic [SLOTS-1:0] cand;
  logic [7:0]  fire_task [SLOTS];
  logic [SLOTS+1:0] tok_valids;

  logic        accept;
  logic        fire_any;
  logic [7:0]  fired_task;
  logic        adv;
  logic        out_free;
  logic        fin_load;
  status_e     fin_status;
  logic [7:0]  fin_task;
  commit_t     commit;
  tok_t        tok_new;

  assign s_axis_tready = !busy_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Token built from an accepted transfer
  always_comb begin
    tok_new           = '0;
    tok_new.valid     = 1'b1;
    tok_new.en        = enable_q;
    tok_new.kind      = s_axis_tuser;
    tok_new.task_id   = s_axis_tdata[7:0] & 8'((1 << TW) - 1);
    tok_new.interval  = s_axis_tdata[39:8];
    tok_new.now       = s_axis_tdata[71:40];
  end

  // Row of slot cells
  assign tok_chain[0] = item_q;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    ostt_cell #(
      .IDX (g),
      .N_W (N_W),
      .TW  (TW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .adv_i       (adv),
      .n_eff_i     (n_eff),
      .tok_i       (tok_chain[g]),
      .commit_i    (commit),
      .tok_o       (tok_chain[g+1]),
      .fire_o      (fire[g]),
      .fire_task_o (fire_task[g]),
      .cand_o      (cand[g])
    );
  end

  // Only one token is ever in flight, so at most one cell fires
  always_comb begin
    fired_task = '0;
    for (int i = 0; i < SLOTS; i++) begin
      fired_task = fired_task | (fire[i] ? fire_task[i] : 8'd0);
    end
  end

  assign fire_any = |fire;
  // A fire pushes the held result out; stall the row if it cannot go
  assign adv      = !(fire_any && hold_valid_q && out_valid_q && !m_axis_tready);

  // Final result of the sweep
  always_comb begin
    fin_task = '0;
    if (!fin_q.en) begin
      fin_status = ST_DISABLED;
    end else if (fin_q.kind == KIND_SCHED) begin
      if (fin_q.pend) begin
        fin_status = ST_PENDING;
      end else if (fin_q.free_seen) begin
        fin_status = ST_SCHEDULED;
      end else begin
        fin_status = ST_FULL;
      end
    end else if (hold_valid_q) begin
      fin_status = ST_FIRED;
      fin_task   = hold_task_q;
    end else begin
      fin_status = ST_NONE;
    end
  end

  assign fin_load = fin_q.valid && out_free;

  // Slot claim at the end of a successful schedule sweep
  always_comb begin
    commit          = '0;
    commit.valid    = fin_load && fin_q.en && (fin_q.kind == KIND_SCHED) &&
                      !fin_q.pend && fin_q.free_seen;
    commit.task_id  = fin_q.task_id;
    commit.interval = fin_q.interval;
    commit.start    = fin_q.now;
  end

  // Item register, sweep end register, busy flag, held fire
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      item_q       <= '0;
      fin_q        <= '0;
      hold_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
        item_q <= tok_new;
      end else if (adv) begin
        item_q.valid <= 1'b0;
      end

      if (adv && tok_chain[SLOTS].valid) begin
        fin_q <= tok_chain[SLOTS];
      end else if (fin_load) begin
        fin_q.valid <= 1'b0;
      end

      if (fin_load) begin
        busy_q       <= 1'b0;
        hold_valid_q <= 1'b0;
      end else if (adv && fire_any) begin
        hold_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && fire_any) begin
      hold_task_q <= fired_task;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_load || (adv && fire_any && hold_valid_q)) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      out_status_q <= fin_status;
      out_task_q   <= fin_task;
      out_last_q   <= 1'b1;
    end else if (adv && fire_any && hold_valid_q) begin
      out_status_q <= ST_FIRED;
      out_task_q   <= hold_task_q;
      out_last_q   <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_task_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

  // Token valid bits across the whole path
  always_comb begin
    tok_valids[0] = item_q.valid;
    for (int i = 0; i < SLOTS; i++) begin
      tok_valids[i+1] = tok_chain[i+1].valid;
    end
    tok_valids[SLOTS+1] = fin_q.valid;
  end

  // Checks
  `OSTT_ASSERT(a_one_token, $onehot0(tok_valids))
  `OSTT_NEVER(a_token_when_idle, !busy_q && (|tok_valids))
  `OSTT_NEVER(a_fire_when_idle, fire_any && !busy_q)
  `OSTT_ASSERT(a_commit_one_slot, commit.valid |-> $onehot(cand))

endmodule

// ===== rtl/ostt_cell.sv =====
// ----------------------------------------------------------------------------
// One-shot timer table: slot cell
// Holds one timer slot. Evaluates the item token passing by, updates the
// token's search flags, fires and clears an expired timer, and takes a
// claim broadcast when it was the first free slot of the sweep.
// ----------------------------------------------------------------------------
module ostt_cell
  import ostt_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned N_W = 5,
  parameter int unsigned TW  = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic [N_W-1:0] n_eff_i,
  input  tok_t           tok_i,
  input  commit_t        commit_i,
  output tok_t           tok_o,
  output logic           fire_o,
  output logic [7:0]     fire_task_o,
  output logic           cand_o
);

  logic          active_q;
  logic          cand_q;
  logic          cand_d;
  logic [31:0]   start_q;
  logic [31:0]   interval_q;
  logic [TW-1:0] task_q;
  tok_t          tok_q;
  tok_t          tok_d;

  logic          in_range;
  logic          live;
  logic          is_sched;
  logic          hit;
  logic          free;
  logic [31:0]   elapsed;

  // Slot evaluation against the token at the cell input
  always_comb begin
    in_range = N_W'(IDX) < n_eff_i;
    live     = tok_i.valid && tok_i.en && in_range;
    is_sched = tok_i.kind == KIND_SCHED;
    elapsed  = tok_i.now - start_q;
    hit      = live && is_sched && active_q && (task_q == tok_i.task_id[TW-1:0]);
    free     = live && is_sched && !active_q;
    fire_o   = live && !is_sched && active_q && (elapsed >= interval_q);
    cand_d   = free && !tok_i.free_seen;

    tok_d           = tok_i;
    tok_d.pend      = tok_i.pend | hit;
    tok_d.free_seen = tok_i.free_seen | free;
  end

  assign fire_task_o = 8'(task_q);
  assign cand_o      = cand_q;
  assign tok_o       = tok_q;

  // Token stage and control bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q    <= '0;
      active_q <= 1'b0;
      cand_q   <= 1'b0;
    end else begin
      if (adv_i) begin
        tok_q <= tok_d;
        if (tok_i.valid) begin
          cand_q <= cand_d;
        end
        if (fire_o) begin
          active_q <= 1'b0;
        end
      end
      if (commit_i.valid && cand_q) begin
        active_q <= 1'b1;
      end
    end
  end

  // Slot payload, written on a claim
  always_ff @(posedge clk_i) begin
    if (commit_i.valid && cand_q) begin
      start_q    <= commit_i.start;
      interval_q <= commit_i.interval;
      task_q     <= commit_i.task_id[TW-1:0];
    end
  end

endmodule

// ===== sim/one_shot_timer_table_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// One-shot timer table core: testbench
// Drives schedule and check items into the timer bank with random gaps on the
// input side and random stalls on the result side. A predictor tracks the
// slot contents and configuration, works out the results each accepted item
// should produce, and the checker compares every result transfer against
// them in order.
// ----------------------------------------------------------------------------
module one_shot_timer_table_core_tb;
  import ostt_pkg::*;

  localparam int unsigned SLOTS         = 16;
  localparam int unsigned TASK_ID_BITS  = 8;
  localparam int unsigned ITEM_TARGET   = 430;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 4 * (SLOTS + 2);
  localparam logic [7:0]  TASK_MASK     = 8'((1 << TASK_ID_BITS) - 1);

  // One result as the bank should report it
  typedef struct packed {
    status_e    status;
    logic [7:0] task_id;
    logic       last;
  } timer_outcome_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic [0:0]       cfg_idx_i     = '0;
  logic [CFG_W-1:0] cfg_wdata_i   = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [71:0]      s_axis_tdata  = '0;  // task_id[7:0], interval_ms[39:8], now_ms[71:40]
  logic             s_axis_tuser  = 1'b0;  // kind[0]
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;  // fired_task[7:0]
  logic [2:0]       m_axis_tuser;  // status[2:0]
  logic             m_axis_tlast;

  // Predicted slot bank and configuration
  bit          slot_busy  [SLOTS];
  logic [31:0] slot_begin [SLOTS];
  logic [31:0] slot_delay [SLOTS];
  logic [7:0]  slot_owner [SLOTS];
  bit          bank_en;
  logic [4:0]  slots_cfg;

  timer_outcome_t expected_outcomes[$];
  timer_outcome_t head_outcome;

  bit          tx_gaps_on   = 1'b1;
  bit          rx_stalls_on = 1'b1;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned items_sent, sched_items, check_items, enabled_items;
  int unsigned results_seen, fired_seen, config_writes;

  one_shot_timer_table_core #(
    .SLOTS       (SLOTS),
    .TASK_ID_BITS(TASK_ID_BITS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               cycle_count, expected_outcomes.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    error_count++;
  endtask

  // Predictor: applies one accepted item to the slot bank and queues its results
  task automatic predict_timer_outcomes(input logic kind, input logic [7:0] tid,
                                        input logic [31:0] ivl, input logic [31:0] now);
    int unsigned    n;
    int unsigned    hits;
    bit             done;
    logic [31:0]    elapsed;
    logic [7:0]     id;
    timer_outcome_t res;
    n  = (slots_cfg > SLOTS) ? SLOTS : slots_cfg;
    id = tid & TASK_MASK;
    items_sent++;
    if (kind == KIND_SCHED) sched_items++;
    else check_items++;
    if (!bank_en) begin
      expected_outcomes.push_back('{ST_DISABLED, 8'd0, 1'b1});
      return;
    end
    enabled_items++;
    if (kind == KIND_SCHED) begin
      done = 1'b0;
      for (int i = 0; i < n; i++)
        if (slot_busy[i] && slot_owner[i] == id) done = 1'b1;
      if (done) begin
        expected_outcomes.push_back('{ST_PENDING, 8'd0, 1'b1});
        return;
      end
      // lowest free slot takes the task
      for (int i = 0; i < n; i++) begin
        if (!done && !slot_busy[i]) begin
          slot_busy[i]  = 1'b1;
          slot_begin[i] = now;
          slot_delay[i] = ivl;
          slot_owner[i] = id;
          done = 1'b1;
        end
      end
      expected_outcomes.push_back('{done ? ST_SCHEDULED : ST_FULL, 8'd0, 1'b1});
    end else begin
      hits = 0;
      for (int i = 0; i < n; i++) begin
        elapsed = now - slot_begin[i];
        if (slot_busy[i] && elapsed >= slot_delay[i]) begin
          expected_outcomes.push_back('{ST_FIRED, slot_owner[i], 1'b0});
          slot_busy[i] = 1'b0;
          hits++;
        end
      end
      if (hits == 0) begin
        expected_outcomes.push_back('{ST_NONE, 8'd0, 1'b1});
      end else begin
        res = expected_outcomes.pop_back();
        res.last = 1'b1;
        expected_outcomes.push_back(res);
      end
    end
  endtask

  // One input transfer, with a random gap ahead of it
  task automatic send_item(input logic kind, input logic [7:0] tid,
                           input logic [31:0] ivl, input logic [31:0] now);
    int unsigned gap;
    gap = tx_gaps_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {now, ivl, tid};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_timer_outcomes(kind, tid, ivl, now);
  endtask

  // Hold the input side until every queued result has been seen
  task automatic wait_for_outcomes();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_outcomes.size() != 0);
  endtask

  // Register write; only called while the bank is idle
  task automatic write_cfg(input logic [0:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_ENABLE) bank_en = val[0];
    else slots_cfg = val;
    config_writes++;
    @(posedge clk_i);
  endtask

  // Result side: random stall ahead of each transfer
  initial begin
    int unsigned stall;
    forever begin
      stall = rx_stalls_on ? $urandom_range(0, 4) : 0;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_outcomes.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d task %0d last %0b",
                                  m_axis_tuser, m_axis_tdata, m_axis_tlast));
      end else begin
        head_outcome = expected_outcomes.pop_front();
        if (m_axis_tuser !== head_outcome.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    m_axis_tuser, head_outcome.status));
        if (m_axis_tdata !== head_outcome.task_id)
          report_mismatch($sformatf("fired_task %0d, expected %0d",
                                    m_axis_tdata, head_outcome.task_id));
        if (m_axis_tlast !== head_outcome.last)
          report_mismatch($sformatf("tlast %0b, expected %0b",
                                    m_axis_tlast, head_outcome.last));
        if (head_outcome.status == ST_FIRED) fired_seen++;
      end
    end
  end

  // Items while the bank is still disabled after reset
  task automatic test_disabled_bank();
    send_item(KIND_SCHED, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(KIND_CHECK, 8'h00, 32'h0000_0000, 32'hFFFF_FFFF);
  endtask

  // Scheduling, duplicate ids, wrapped elapsed time and the extreme intervals
  task automatic test_schedule_and_expiry();
    wait_for_outcomes();
    write_cfg(CFG_ENABLE, 5'd1);
    write_cfg(CFG_SLOTS, 5'(SLOTS));
    send_item(KIND_SCHED, 8'h00, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(KIND_SCHED, 8'h00, 32'h0000_0001, 32'h0000_0000);  // already pending
    send_item(KIND_SCHED, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0005);
    send_item(KIND_SCHED, 8'hA5, 32'h0000_0020, 32'hFFFF_FFF0);
    // first two fire across the wrap, the third is one short
    send_item(KIND_CHECK, 8'h00, 32'h0000_0000, 32'h0000_0004);
    send_item(KIND_CHECK, 8'h00, 32'h0000_0000, 32'h0000_000F);
    send_item(KIND_CHECK, 8'h00, 32'h0000_0000, 32'h0000_0010);
    send_item(KIND_CHECK, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0010);  // empty bank
  endtask

  // Narrow, zero and oversized slot counts; hidden slots keep their tasks
  task automatic test_slot_limits();
    wait_for_outcomes();
    write_cfg(CFG_SLOTS, 5'd2);
    send_item(KIND_SCHED, 8'h01, 32'd100, 32'd0);
    send_item(KIND_SCHED, 8'h02, 32'd100, 32'd0);
    send_item(KIND_SCHED, 8'h03, 32'd100, 32'd0);  // no free slot
    wait_for_outcomes();
    write_cfg(CFG_SLOTS, 5'd0);
    send_item(KIND_SCHED, 8'h04, 32'd0, 32'd0);
    send_item(KIND_CHECK, 8'h00, 32'd0, 32'd1000);
    wait_for_outcomes();
    write_cfg(CFG_SLOTS, 5'd1);
    send_item(KIND_CHECK, 8'h00, 32'd0, 32'd1000);
    // toggling enable must leave the slots alone
    wait_for_outcomes();
    write_cfg(CFG_ENABLE, 5'd0);
    send_item(KIND_CHECK, 8'h00, 32'd0, 32'd1000);
    wait_for_outcomes();
    write_cfg(CFG_ENABLE, 5'd1);
    write_cfg(CFG_SLOTS, 5'd31);
    send_item(KIND_CHECK, 8'h00, 32'd0, 32'd1000);
    wait_for_outcomes();
    write_cfg(CFG_SLOTS, 5'd17);
    send_item(KIND_SCHED, 8'h05, 32'd0, 32'd7);
    send_item(KIND_CHECK, 8'h00, 32'd0, 32'd7);
  endtask

  // One phase of random traffic under a fresh configuration
  task automatic run_timer_episode();
    int unsigned len, roll, burst_n;
    logic [7:0]  id_pool [8];
    logic [7:0]  burst_base;
    logic [31:0] ep_now;
    logic [4:0]  slots_val;
    wait_for_outcomes();
    roll = $urandom_range(0, 9);
    case (roll)
      0:       slots_val = 5'd0;
      1:       slots_val = 5'd1;
      2:       slots_val = 5'd31;
      3:       slots_val = 5'($urandom_range(17, 30));
      4, 5, 6: slots_val = 5'(SLOTS);
      default: slots_val = 5'($urandom_range(2, 15));
    endcase
    write_cfg(CFG_SLOTS, slots_val);
    write_cfg(CFG_ENABLE, ($urandom_range(0, 7) != 0) ? 5'd1 : 5'd0);
    tx_gaps_on   = ($urandom_range(0, 2) != 0);
    rx_stalls_on = ($urandom_range(0, 2) != 0);
    foreach (id_pool[k]) id_pool[k] = 8'($urandom);
    ep_now = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255)
                                         : $urandom;
    // fill many slots from one instant, then expire them together
    if (bank_en && $urandom_range(0, 3) == 0) begin
      burst_n    = $urandom_range(1, SLOTS + 2);
      burst_base = 8'($urandom);
      for (int k = 0; k < burst_n; k++)
        send_item(KIND_SCHED, burst_base + 8'(k), $urandom_range(0, 8), ep_now);
      ep_now += 8;
      send_item(KIND_CHECK, 8'($urandom), $urandom, ep_now);
    end
    len = $urandom_range(15, 40);
    repeat (len) begin
      if (items_sent >= ITEM_TARGET) break;
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        send_item(1'($urandom_range(0, 1)), 8'($urandom), $urandom, $urandom);
      end else if (roll < 55) begin
        send_item(KIND_SCHED, id_pool[$urandom_range(0, 7)],
                  (roll < 50) ? 32'($urandom_range(0, 30)) : 32'($urandom), ep_now);
      end else begin
        ep_now += (roll < 97) ? 32'($urandom_range(0, 12)) : 32'($urandom);
        send_item(KIND_CHECK, 8'($urandom), $urandom, ep_now);
      end
    end
  endtask

  // Random episodes until the item budget is used up
  task automatic test_random_traffic();
    while (items_sent < ITEM_TARGET) run_timer_episode();
  endtask

  // Test sequence
  initial begin
    bank_en   = 1'b0;
    slots_cfg = 5'(SLOTS_RST);
    foreach (slot_busy[i]) slot_busy[i] = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_disabled_bank();
    test_schedule_and_expiry();
    test_slot_limits();
    test_random_traffic();

    wait_for_outcomes();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_outcomes.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_outcomes.size()));

    $display("Covered %0d items (%0d schedule, %0d check, %0d with bank enabled)",
             items_sent, sched_items, check_items, enabled_items);
    $display("Checked %0d results (%0d fired tasks) across %0d register writes",
             results_seen, fired_seen, config_writes);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== one_shot_timer_table_core.f =====
+incdir+rtl
rtl/ostt_pkg.sv
rtl/ostt_cell.sv
rtl/one_shot_timer_table_core.sv
sim/one_shot_timer_table_core_tb.sv
